### sv/shake_integrator_hit_detector_macros.svh
// ----------------------------------------------------------------------------
// Shake integrator hit detector - assertion macros
// Shared property forms used by the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SHAKE_INTEGRATOR_HIT_DETECTOR_MACROS_SVH
`define SHAKE_INTEGRATOR_HIT_DETECTOR_MACROS_SVH

// same-cycle implication
`define SHID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/shid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shid_pkg
// Widths, register codes, defaults and shared types of the shake integrator.
// ----------------------------------------------------------------------------
package shid_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int CHANGE_W    = 18;
    localparam int LEVEL_W     = 17;
    localparam int GAIN_W      = 8;
    localparam int FADE_W      = 16;
    localparam int SCALED_W    = CHANGE_W + GAIN_W;
    localparam int T_W         = SCALED_W + 2;
    localparam int PROD_W      = SCALED_W + FADE_W;
    localparam int NUM_AXES    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam int DEF_MAX_LEVEL        = 76800;
    localparam int DEF_WINDOW_DELAY_MS  = 1200;
    localparam int DEF_WINDOW_LENGTH_MS = 2500;
    localparam int DEF_SAMPLE_BITS      = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEL_THRESHOLD  = 3'd0,
        CFG_CHANGE_CUTOFF    = 3'd1,
        CFG_MAX_CHANGE       = 3'd2,
        CFG_INTEGRATION_GAIN = 3'd3,
        CFG_FADE_OFFSET      = 3'd4,
        CFG_FADE_SCALING     = 3'd5,
        CFG_HIT_START_LEVEL  = 3'd6,
        CFG_HIT_MIN_CHANGE   = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_SCALE,
        ST_PRODUCT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [SAMPLE_W-1:0] accel_threshold;
        logic [CHANGE_W-1:0] change_cutoff;
        logic [CHANGE_W-1:0] max_change;
        logic [GAIN_W-1:0]   integration_gain;
        logic [LEVEL_W-1:0]  fade_offset;
        logic [FADE_W-1:0]   fade_scaling;
        logic [LEVEL_W-1:0]  hit_start_level;
        logic [CHANGE_W-1:0] hit_min_change;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        accel_threshold:  16'd1,
        change_cutoff:    18'd10,
        max_change:       18'd50,
        integration_gain: 8'd41,
        fade_offset:      17'd384,
        fade_scaling:     16'd62259,
        hit_start_level:  17'd3840,
        hit_min_change:   18'd300
    };

    typedef struct packed {
        logic scale;
        logic product;
        logic finish;
    } t_integ_ctrl;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               armed;
        logic               hit_seen;
        logic               window_expired;
        logic               just_armed;
    } t_result;

endpackage

### sv/shake_integrator_hit_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shake_integrator_hit_detector
// Three axis lanes, a merge stage and a leaky integrator with hit window.
//
//   channel  direction  handshake               payload
//   in       sink       i_in_valid/o_in_stall   i_axis_x/y/z, i_sample_time_ms
//   out      source     o_out_valid/i_out_stall o_level, o_armed, o_hit_seen,
//                                               o_window_expired, o_just_armed
//   cfg      sink       i_cfg_wr_en             i_cfg_index, i_cfg_data
//
// Each beat passes through five steps in turn: accept (lanes), merge, scale, product, finish.
// The finish step holds while the output register still holds an untaken beat.
// o_in_stall is high from accept until the finish step has loaded the result.
// Synchronous active-low reset clears lane history, integrator and window.
// ----------------------------------------------------------------------------
module shake_integrator_hit_detector #(
    parameter int MAX_LEVEL        = shid_pkg::DEF_MAX_LEVEL,
    parameter int WINDOW_DELAY_MS  = shid_pkg::DEF_WINDOW_DELAY_MS,
    parameter int WINDOW_LENGTH_MS = shid_pkg::DEF_WINDOW_LENGTH_MS,
    parameter int SAMPLE_BITS      = shid_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [shid_pkg::SAMPLE_W-1:0]    i_axis_x,
    input  logic [shid_pkg::SAMPLE_W-1:0]    i_axis_y,
    input  logic [shid_pkg::SAMPLE_W-1:0]    i_axis_z,
    input  logic [shid_pkg::TIME_W-1:0]      i_sample_time_ms,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [shid_pkg::LEVEL_W-1:0]     o_level,
    output logic                             o_armed,
    output logic                             o_hit_seen,
    output logic                             o_window_expired,
    output logic                             o_just_armed,
    input  logic                             i_cfg_wr_en,
    input  logic [shid_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [shid_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    shid_pkg::t_state      r_state, n_state;
    shid_pkg::t_cfg        r_cfg;
    shid_pkg::t_integ_ctrl ctrl;
    shid_pkg::t_result     result;
    shid_pkg::t_result     r_out;
    logic                  r_out_valid;
    logic [shid_pkg::TIME_W-1:0] r_time;
    logic                  accept;
    logic                  out_free;
    logic                  merge_load;

    logic [shid_pkg::SAMPLE_W-1:0] axis   [shid_pkg::NUM_AXES];
    logic [shid_pkg::SAMPLE_W-1:0] contrib[shid_pkg::NUM_AXES];
    logic [shid_pkg::CHANGE_W-1:0] change;

    assign axis[0] = i_axis_x;
    assign axis[1] = i_axis_y;
    assign axis[2] = i_axis_z;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= shid_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (shid_pkg::t_cfg_index'(i_cfg_index))
                shid_pkg::CFG_ACCEL_THRESHOLD:
                    r_cfg.accel_threshold <= i_cfg_data[shid_pkg::SAMPLE_W-1:0];
                shid_pkg::CFG_CHANGE_CUTOFF:
                    r_cfg.change_cutoff <= i_cfg_data[shid_pkg::CHANGE_W-1:0];
                shid_pkg::CFG_MAX_CHANGE:
                    r_cfg.max_change <= i_cfg_data[shid_pkg::CHANGE_W-1:0];
                shid_pkg::CFG_INTEGRATION_GAIN:
                    r_cfg.integration_gain <= i_cfg_data[shid_pkg::GAIN_W-1:0];
                shid_pkg::CFG_FADE_OFFSET:
                    r_cfg.fade_offset <= i_cfg_data[shid_pkg::LEVEL_W-1:0];
                shid_pkg::CFG_FADE_SCALING:
                    r_cfg.fade_scaling <= i_cfg_data[shid_pkg::FADE_W-1:0];
                shid_pkg::CFG_HIT_START_LEVEL:
                    r_cfg.hit_start_level <= i_cfg_data[shid_pkg::LEVEL_W-1:0];
                shid_pkg::CFG_HIT_MIN_CHANGE:
                    r_cfg.hit_min_change <= i_cfg_data[shid_pkg::CHANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shid_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_stall   = 1'b1;
        merge_load   = 1'b0;
        ctrl         = '0;
        unique case (r_state)
            shid_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = shid_pkg::ST_MERGE;
                end
            end
            shid_pkg::ST_MERGE: begin
                merge_load = 1'b1;
                n_state    = shid_pkg::ST_SCALE;
            end
            shid_pkg::ST_SCALE: begin
                ctrl.scale = 1'b1;
                n_state    = shid_pkg::ST_PRODUCT;
            end
            shid_pkg::ST_PRODUCT: begin
                ctrl.product = 1'b1;
                n_state      = shid_pkg::ST_FINISH;
            end
            shid_pkg::ST_FINISH: begin
                if (out_free) begin
                    ctrl.finish = 1'b1;
                    n_state     = shid_pkg::ST_IDLE;
                end
            end
            default: n_state = shid_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time <= i_sample_time_ms;
        end
    end

    genvar g;
    generate
        for (g = 0; g < shid_pkg::NUM_AXES; g++) begin : g_lane
            shid_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (accept),
                .i_sample    (axis[g]),
                .i_threshold (r_cfg.accel_threshold),
                .o_contrib   (contrib[g])
            );
        end
    endgenerate

    shid_merge u_merge (
        .i_clk     (i_clk),
        .i_load    (merge_load),
        .i_contrib (contrib),
        .i_cutoff  (r_cfg.change_cutoff),
        .o_change  (change)
    );

    shid_integ #(
        .MAX_LEVEL        (MAX_LEVEL),
        .WINDOW_DELAY_MS  (WINDOW_DELAY_MS),
        .WINDOW_LENGTH_MS (WINDOW_LENGTH_MS)
    ) u_integ (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_cfg    (r_cfg),
        .i_change (change),
        .i_time   (r_time),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.finish) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_level          = r_out.level;
    assign o_armed          = r_out.armed;
    assign o_hit_seen       = r_out.hit_seen;
    assign o_window_expired = r_out.window_expired;
    assign o_just_armed     = r_out.just_armed;

`include "shake_integrator_hit_detector_macros.svh"

    `SHID_ASSERT_IMP(a_hit_xor_expire, i_clk, i_rst_n, o_out_valid,
        !(o_hit_seen && o_window_expired), "hit and window expiry on one beat")
    `SHID_ASSERT_IMP(a_just_armed_armed, i_clk, i_rst_n, o_out_valid && o_just_armed,
        o_armed, "just_armed without armed")
    `SHID_ASSERT_IMP(a_level_max, i_clk, i_rst_n, o_out_valid,
        o_level <= shid_pkg::LEVEL_W'(MAX_LEVEL), "level above maximum")
    `SHID_ASSERT_NXT(a_finish_loads, i_clk, i_rst_n, ctrl.finish,
        o_out_valid && r_state == shid_pkg::ST_IDLE, "finish did not present a beat")

endmodule

### sv/shid_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shid_lane
// One axis: change against the last kept value, threshold test, keep update.
// ----------------------------------------------------------------------------
module shid_lane #(
    parameter int SAMPLE_BITS = shid_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [shid_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [shid_pkg::SAMPLE_W-1:0] i_threshold,
    output logic [shid_pkg::SAMPLE_W-1:0] o_contrib
);

    localparam int DW = shid_pkg::SAMPLE_W + 1;

    logic [shid_pkg::SAMPLE_W-1:0] r_last;
    logic [shid_pkg::SAMPLE_W-1:0] r_contrib;
    logic signed [DW-1:0]          cur_ext;
    logic signed [DW-1:0]          prev_ext;
    logic signed [DW-1:0]          diff;
    logic [DW-1:0]                 abs_diff;
    logic                          take;

    always_comb begin
        cur_ext  = $signed({{(DW-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}},
                            i_sample[SAMPLE_BITS-1:0]});
        prev_ext = $signed({{(DW-SAMPLE_BITS){r_last[SAMPLE_BITS-1]}},
                            r_last[SAMPLE_BITS-1:0]});
        diff     = cur_ext - prev_ext;
        abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);
        take     = abs_diff > {1'b0, i_threshold};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_contrib <= '0;
        end else if (i_load) begin
            // |diff| never exceeds 65535, so the top bit is always clear
            r_contrib <= take ? abs_diff[shid_pkg::SAMPLE_W-1:0] : '0;
            if (take) begin
                r_last <= cur_ext[shid_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign o_contrib = r_contrib;

endmodule

### sv/shid_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shid_merge
// Sums the lane changes and takes off the cutoff, floor zero.
// ----------------------------------------------------------------------------
module shid_merge (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [shid_pkg::SAMPLE_W-1:0] i_contrib [shid_pkg::NUM_AXES],
    input  logic [shid_pkg::CHANGE_W-1:0] i_cutoff,
    output logic [shid_pkg::CHANGE_W-1:0] o_change
);

    logic [shid_pkg::CHANGE_W-1:0] r_change;
    logic [shid_pkg::CHANGE_W-1:0] sum;

    always_comb begin
        sum = '0;
        for (int k = 0; k < shid_pkg::NUM_AXES; k++) begin
            sum = sum + shid_pkg::CHANGE_W'(i_contrib[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_change <= (sum > i_cutoff) ? sum - i_cutoff : '0;
        end
    end

    assign o_change = r_change;

endmodule

### sv/shid_integ.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shid_integ
// Hit window check, gain scaling and leaky Q.8 integrator with arming.
// ----------------------------------------------------------------------------
module shid_integ #(
    parameter int MAX_LEVEL        = shid_pkg::DEF_MAX_LEVEL,
    parameter int WINDOW_DELAY_MS  = shid_pkg::DEF_WINDOW_DELAY_MS,
    parameter int WINDOW_LENGTH_MS = shid_pkg::DEF_WINDOW_LENGTH_MS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  shid_pkg::t_integ_ctrl         i_ctrl,
    input  shid_pkg::t_cfg                i_cfg,
    input  logic [shid_pkg::CHANGE_W-1:0] i_change,
    input  logic [shid_pkg::TIME_W-1:0]   i_time,
    output shid_pkg::t_result             o_result
);

    localparam int WIN_END = WINDOW_DELAY_MS + WINDOW_LENGTH_MS;
    localparam int LV_W    = shid_pkg::PROD_W - shid_pkg::FADE_W;

    logic [shid_pkg::LEVEL_W-1:0]  r_integrator;
    logic                          r_active;
    logic [shid_pkg::TIME_W-1:0]   r_arm_time;
    logic [shid_pkg::SCALED_W-1:0] r_scaled;
    logic [shid_pkg::PROD_W-1:0]   r_prod;
    logic                          r_hit;
    logic                          r_expired;

    logic [shid_pkg::TIME_W-1:0]   elapsed;
    logic                          past_delay;
    logic                          in_window;
    logic                          n_hit;
    logic                          n_expired;
    logic [shid_pkg::CHANGE_W-1:0] clamped;
    logic [shid_pkg::SCALED_W-1:0] n_scaled;
    logic signed [shid_pkg::T_W-1:0] t_sum;
    logic [shid_pkg::PROD_W-1:0]   n_prod;
    logic [LV_W-1:0]               lv;
    logic [shid_pkg::LEVEL_W-1:0]  level;
    logic                          arm;

    always_comb begin
        elapsed    = i_time - r_arm_time;
        past_delay = elapsed > shid_pkg::TIME_W'(WINDOW_DELAY_MS);
        in_window  = elapsed < shid_pkg::TIME_W'(WIN_END);
        n_hit      = r_active && past_delay && in_window
                     && (i_change > i_cfg.hit_min_change);
        n_expired  = r_active && past_delay && !in_window;
        clamped    = (i_change > i_cfg.max_change) ? i_cfg.max_change : i_change;
        n_scaled   = shid_pkg::SCALED_W'(clamped)
                     * shid_pkg::SCALED_W'(i_cfg.integration_gain);
    end

    always_comb begin
        t_sum = $signed(shid_pkg::T_W'(r_integrator)) + $signed(shid_pkg::T_W'(r_scaled))
                - $signed(shid_pkg::T_W'(i_cfg.fade_offset));
        // non-positive sum leaks straight to zero
        if (t_sum[shid_pkg::T_W-1] || (t_sum == '0)) begin
            n_prod = '0;
        end else begin
            n_prod = shid_pkg::PROD_W'(t_sum[shid_pkg::SCALED_W-1:0])
                     * shid_pkg::PROD_W'(i_cfg.fade_scaling);
        end
    end

    always_comb begin
        lv    = r_prod[shid_pkg::PROD_W-1:shid_pkg::FADE_W];
        level = (lv > LV_W'(MAX_LEVEL)) ? shid_pkg::LEVEL_W'(MAX_LEVEL)
                                        : lv[shid_pkg::LEVEL_W-1:0];
        arm   = !r_active && (level >= i_cfg.hit_start_level);
        o_result.level          = level;
        o_result.armed          = r_active || arm;
        o_result.hit_seen       = r_hit;
        o_result.window_expired = r_expired;
        o_result.just_armed     = arm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integrator <= '0;
            r_active     <= 1'b0;
            r_arm_time   <= '0;
            r_hit        <= 1'b0;
            r_expired    <= 1'b0;
        end else begin
            if (i_ctrl.scale) begin
                r_hit     <= n_hit;
                r_expired <= n_expired;
                if (n_hit || n_expired) begin
                    r_active <= 1'b0;
                end
            end
            if (i_ctrl.finish) begin
                r_integrator <= level;
                if (arm) begin
                    r_active   <= 1'b1;
                    r_arm_time <= i_time;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scale) begin
            r_scaled <= n_scaled;
        end
        if (i_ctrl.product) begin
            r_prod <= n_prod;
        end
    end

endmodule
